/* rtl/core/scjc_pkg.sv */
// shared types, constants and helpers for the spike count to joint command unit
`default_nettype none
package scjc_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int NET_W      = CNT_W + 1;
	localparam int GAIN_W     = 33;
	localparam int PROD_W     = GAIN_W + NET_W;
	localparam int ENTRY_W    = 3 + 64;
	localparam int QSHIFT     = 16;
	localparam int QDEPTH     = 2;
	localparam int QAW        = $clog2(QDEPTH);
	localparam int QCW        = $clog2(QDEPTH + 1);
	localparam int NUM_LAYERS = 6;
	localparam int NUM_JOINTS = 3;
	localparam int JNT_W      = $clog2(NUM_JOINTS);

	localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(RING_DEPTH);
	localparam logic [9:0] STALE_MAX = 10'd1023;

	localparam logic signed [PROD_W-1:0] SAT_HI     = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] SAT_LO     = ~SAT_HI;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(65535);

	// opcodes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// tick modes
	localparam logic [2:0] MODE_CONTROL = 3'd2;
	localparam logic [2:0] MODE_INVALID = 3'd7;

	// highest valid layer code
	localparam logic [2:0] LAYER_MAX = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_MODE  = 2'd1;
	localparam logic [1:0] STAT_BAD_LAYER = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	// register indexes
	localparam logic [2:0] REG_PERIOD       = 3'd0;
	localparam logic [2:0] REG_BASE_PPD     = 3'd1;
	localparam logic [2:0] REG_SHOULDER_PPD = 3'd2;
	localparam logic [2:0] REG_ELBOW_PPD    = 3'd3;
	localparam logic [2:0] REG_GAIN         = 3'd4;

	// joint selects
	localparam logic [JNT_W-1:0] JNT_BASE     = JNT_W'(0);
	localparam logic [JNT_W-1:0] JNT_SHOULDER = JNT_W'(1);
	localparam logic [JNT_W-1:0] JNT_ELBOW    = JNT_W'(2);

	typedef struct packed {
		logic        opcode;
		logic [63:0] time_stamp;
		logic [2:0]  spike_layer;
		logic [2:0]  object_mode;
	} item_t;

	typedef struct packed {
		logic [1:0]         status_code;
		logic               commands_valid;
		logic signed [15:0] base_change;
		logic signed [15:0] shoulder_change;
		logic signed [15:0] elbow_change;
		logic [9:0]         stale_dropped;
	} result_t;

	typedef struct packed {
		logic [7:0]         period;
		logic [15:0]        base_ppd;
		logic [15:0]        shoulder_ppd;
		logic [15:0]        elbow_ppd;
		logic signed [15:0] gain;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECODE,
		BK_DRAIN_RD,
		BK_DRAIN_CHK,
		BK_MUL_A,
		BK_MUL_B,
		BK_SCALE
	} back_state_t;

	function automatic logic [RING_AW-1:0] next_ptr(input logic [RING_AW-1:0] p);
		return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/scjc_front.sv */
// intake stage: accepts items into a short queue ahead of the execution sequencer
`default_nettype none
module scjc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           opcode,
	input  wire logic [63:0]    time_stamp,
	input  wire logic [2:0]     spike_layer,
	input  wire logic [2:0]     object_mode,
	input  wire logic           q_pop,
	output logic                busy,
	output logic                q_valid,
	output scjc_pkg::item_t     q_head
);
	import scjc_pkg::*;

	item_t            fifo_q [QDEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   fill_q;
	logic             push;

	assign busy    = (fill_q == QCW'(QDEPTH));
	assign q_valid = (fill_q != '0);
	assign q_head  = fifo_q[rd_q];
	assign push    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{opcode: opcode, time_stamp: time_stamp,
				spike_layer: spike_layer, object_mode: object_mode};
		end
	end

endmodule
`default_nettype wire

/* rtl/core/scjc_back.sv */
// execution sequencer: spike ring, drain walk and serial joint scaling
`default_nettype none
module scjc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire scjc_pkg::cfg_t cfg,
	input  wire logic           q_valid,
	input  wire scjc_pkg::item_t q_head,
	output logic                q_pop,
	output logic                done,
	output scjc_pkg::result_t   res
);
	import scjc_pkg::*;

	back_state_t               state_q, state_d;
	item_t                     cur_q, cur_d;
	logic [RING_AW-1:0]        rd_ptr_q, rd_d;
	logic [RING_AW-1:0]        wr_ptr_q, wr_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [63:0]               last_q, last_d;
	logic [7:0]                tick_q, tick_d;
	logic [9:0]                stale_q, stale_d;
	logic [CNT_W-1:0]          cnt_q [NUM_LAYERS];
	logic [CNT_W-1:0]          cnt_d [NUM_LAYERS];
	logic [JNT_W-1:0]          jnt_q, jnt_d;
	logic signed [GAIN_W-1:0]  prod_a_q, prod_a_d;
	logic signed [PROD_W-1:0]  prod_b_q, prod_b_d;
	logic signed [15:0]        chg_q [NUM_JOINTS];
	logic signed [15:0]        chg_d [NUM_JOINTS];
	logic                      done_q, done_d;
	result_t                   res_q, res_d;

	logic [ENTRY_W-1:0]        ring_q [RING_DEPTH];
	logic [ENTRY_W-1:0]        rd_data_q;
	logic                      mem_we;

	logic [63:0]               rd_time;
	logic [2:0]                rd_layer;
	logic                      is_control;
	logic                      drain_done;
	logic [15:0]               sel_ppd;
	logic signed [NET_W-1:0]   sel_net;
	logic signed [PROD_W-1:0]  adj;
	logic signed [PROD_W-1:0]  shf;
	logic signed [15:0]        sat_val;

	assign rd_time    = rd_data_q[63:0];
	assign rd_layer   = rd_data_q[ENTRY_W-1:64];
	assign is_control = (cur_q.object_mode == MODE_CONTROL);
	assign done       = done_q;
	assign res        = res_q;

	// operand select for the joint in progress
	always_comb begin
		case (jnt_q)
			JNT_BASE: begin
				sel_ppd = cfg.base_ppd;
				sel_net = NET_W'({1'b0, cnt_q[1]}) - NET_W'({1'b0, cnt_q[0]});
			end
			JNT_SHOULDER: begin
				sel_ppd = cfg.shoulder_ppd;
				sel_net = NET_W'({1'b0, cnt_q[3]}) - NET_W'({1'b0, cnt_q[2]});
			end
			JNT_ELBOW: begin
				sel_ppd = cfg.elbow_ppd;
				sel_net = NET_W'({1'b0, cnt_q[5]}) - NET_W'({1'b0, cnt_q[4]});
			end
			default: begin
				sel_ppd = '0;
				sel_net = '0;
			end
		endcase
	end

	// divide by 2^16 toward zero, then clamp to 16 bits
	always_comb begin
		adj = prod_b_q + (prod_b_q[PROD_W-1] ? ROUND_BIAS : '0);
		shf = adj >>> QSHIFT;
		if (shf > SAT_HI) begin
			sat_val = 16'sh7fff;
		end else if (shf < SAT_LO) begin
			sat_val = -16'sh8000;
		end else begin
			sat_val = shf[15:0];
		end
	end

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		rd_d       = rd_ptr_q;
		wr_d       = wr_ptr_q;
		count_d    = count_q;
		last_d     = last_q;
		tick_d     = tick_q;
		stale_d    = stale_q;
		cnt_d      = cnt_q;
		jnt_d      = jnt_q;
		prod_a_d   = prod_a_q;
		prod_b_d   = prod_b_q;
		chg_d      = chg_q;
		done_d     = 1'b0;
		res_d      = '0;
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		drain_done = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cur_d   = q_head;
					state_d = BK_DECODE;
				end
			end
			BK_DECODE: begin
				state_d = BK_IDLE;
				if (cur_q.opcode == OP_PUSH) begin
					done_d = 1'b1;
					if (count_q == RING_FULL) begin
						res_d.status_code = STAT_FULL;
					end else begin
						mem_we  = 1'b1;
						wr_d    = next_ptr(wr_ptr_q);
						count_d = count_q + 1'b1;
					end
				end else if (cur_q.object_mode == MODE_INVALID) begin
					done_d            = 1'b1;
					res_d.status_code = STAT_BAD_MODE;
				end else if (is_control && tick_q != cfg.period) begin
					tick_d               = tick_q + 1'b1;
					done_d               = 1'b1;
					res_d.commands_valid = 1'b1;
				end else begin
					stale_d = '0;
					for (int i = 0; i < NUM_LAYERS; i++) begin
						cnt_d[i] = '0;
					end
					state_d = BK_DRAIN_RD;
				end
			end
			BK_DRAIN_RD: begin
				// head entry lands in rd_data_q at the end of this cycle
				if (count_q == '0) begin
					drain_done = 1'b1;
				end else begin
					state_d = BK_DRAIN_CHK;
				end
			end
			BK_DRAIN_CHK: begin
				if (rd_time < last_q) begin
					rd_d    = next_ptr(rd_ptr_q);
					count_d = count_q - 1'b1;
					if (stale_q != STALE_MAX) begin
						stale_d = stale_q + 1'b1;
					end
					state_d = BK_DRAIN_RD;
				end else if (rd_time >= cur_q.time_stamp) begin
					drain_done = 1'b1;
				end else begin
					rd_d    = next_ptr(rd_ptr_q);
					count_d = count_q - 1'b1;
					if (is_control && rd_layer > LAYER_MAX) begin
						done_d              = 1'b1;
						res_d.status_code   = STAT_BAD_LAYER;
						res_d.stale_dropped = stale_q;
						state_d             = BK_IDLE;
					end else begin
						if (is_control) begin
							for (int i = 0; i < NUM_LAYERS; i++) begin
								if (rd_layer == 3'(i)) begin
									cnt_d[i] = cnt_q[i] + 1'b1;
								end
							end
						end
						state_d = BK_DRAIN_RD;
					end
				end
			end
			BK_MUL_A: begin
				prod_a_d = $signed({1'b0, sel_ppd}) * cfg.gain;
				state_d  = BK_MUL_B;
			end
			BK_MUL_B: begin
				prod_b_d = prod_a_q * sel_net;
				state_d  = BK_SCALE;
			end
			BK_SCALE: begin
				chg_d[jnt_q] = sat_val;
				if (jnt_q == JNT_ELBOW) begin
					done_d                = 1'b1;
					res_d.commands_valid  = 1'b1;
					res_d.base_change     = chg_q[JNT_BASE];
					res_d.shoulder_change = chg_q[JNT_SHOULDER];
					res_d.elbow_change    = sat_val;
					res_d.stale_dropped   = stale_q;
					tick_d                = '0;
					last_d                = cur_q.time_stamp;
					state_d               = BK_IDLE;
				end else begin
					jnt_d   = jnt_q + 1'b1;
					state_d = BK_MUL_A;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase

		if (drain_done) begin
			if (is_control) begin
				jnt_d   = JNT_BASE;
				state_d = BK_MUL_A;
			end else begin
				done_d              = 1'b1;
				res_d.stale_dropped = stale_q;
				tick_d              = '0;
				last_d              = cur_q.time_stamp;
				state_d             = BK_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			last_q   <= '0;
			tick_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_ptr_q <= rd_d;
			wr_ptr_q <= wr_d;
			count_q  <= count_d;
			last_q   <= last_d;
			tick_q   <= tick_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		stale_q  <= stale_d;
		cnt_q    <= cnt_d;
		jnt_q    <= jnt_d;
		prod_a_q <= prod_a_d;
		prod_b_q <= prod_b_d;
		chg_q    <= chg_d;
		res_q    <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[wr_ptr_q] <= {cur_q.spike_layer, cur_q.time_stamp};
		end
		rd_data_q <= ring_q[rd_ptr_q];
	end

endmodule
`default_nettype wire

/* rtl/core/spike_count_to_joint_command_unit.sv */
// top level: configuration registers, intake queue and execution sequencer
// a push, an invalid-mode tick or an early control tick gets its result from the decode step
// the back sequencer fetches and decodes each push before it takes the next item
// a draining tick examines each ring entry with a registered ring read, then a compare
// a control evaluation then runs two multiplies and a scale serially for each of the three joints
// reset clears pointers, counts, tick state; sets config defaults; ring contents not cleared
`default_nettype none
module spike_count_to_joint_command_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [63:0]        time_stamp,
	input  wire logic [2:0]         spike_layer,
	input  wire logic [2:0]         object_mode,
	output logic                    done,
	output logic [1:0]              status_code,
	output logic                    commands_valid,
	output logic signed [15:0]      base_change,
	output logic signed [15:0]      shoulder_change,
	output logic signed [15:0]      elbow_change,
	output logic [9:0]              stale_dropped
);
	import scjc_pkg::*;

	cfg_t    cfg_q;
	logic    q_valid;
	logic    q_pop;
	item_t   q_head;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period       <= 8'd0;
			cfg_q.base_ppd     <= 16'd256;
			cfg_q.shoulder_ppd <= 16'd256;
			cfg_q.elbow_ppd    <= 16'd256;
			cfg_q.gain         <= 16'sd256;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PERIOD:       cfg_q.period       <= cfg_data[7:0];
				REG_BASE_PPD:     cfg_q.base_ppd     <= cfg_data;
				REG_SHOULDER_PPD: cfg_q.shoulder_ppd <= cfg_data;
				REG_ELBOW_PPD:    cfg_q.elbow_ppd    <= cfg_data;
				REG_GAIN:         cfg_q.gain         <= $signed(cfg_data);
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	scjc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.time_stamp  (time_stamp),
		.spike_layer (spike_layer),
		.object_mode (object_mode),
		.q_pop       (q_pop),
		.busy        (busy),
		.q_valid     (q_valid),
		.q_head      (q_head)
	);

	scjc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.done    (done),
		.res     (res)
	);

	assign status_code     = res.status_code;
	assign commands_valid  = res.commands_valid;
	assign base_change     = res.base_change;
	assign shoulder_change = res.shoulder_change;
	assign elbow_change    = res.elbow_change;
	assign stale_dropped   = res.stale_dropped;

endmodule
`default_nettype wire

/* rtl/core/scjc_checker.sv */
// port-level checks for the spike count to joint command unit, bound to the top level
`default_nettype none
module scjc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic [1:0]         status_code,
	input wire logic               commands_valid,
	input wire logic signed [15:0] base_change,
	input wire logic signed [15:0] shoulder_change,
	input wire logic signed [15:0] elbow_change,
	input wire logic [9:0]         stale_dropped
);
	import scjc_pkg::*;

	// results of separate items are never strobed in back-to-back cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	a_err_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_code != STAT_OK |-> !commands_valid)
		else $error("commands issued with an error status");

	a_no_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !commands_valid |->
			base_change == 16'sd0 && shoulder_change == 16'sd0 && elbow_change == 16'sd0)
		else $error("joint changes nonzero without commands");

	a_bad_mode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_code == STAT_BAD_MODE || status_code == STAT_FULL)
			|-> stale_dropped == 10'd0)
		else $error("stale count reported on a rejected item");

endmodule

bind spike_count_to_joint_command_unit scjc_checker u_scjc_checker (.*);
`default_nettype wire
